// ===== hdl/spr_pkg.sv =====
// ----------------------------------------------------------------------------
// spr_pkg
// Types, field widths, status codes and controller commands shared by the
// slotted page row store.
// ----------------------------------------------------------------------------
package spr_pkg;

  localparam int LEN_W   = 13;
  localparam int BYTE_W  = 8;
  localparam int SLOT_W  = 10;
  localparam int INDEX_W = 12;
  localparam int STAT_W  = 2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_SLOT  = 2'd2;
  localparam logic [STAT_W-1:0] ST_PAST_END = 2'd3;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [LEN_W-1:0]   row_length;
    logic               row_first;
    logic [BYTE_W-1:0]  data_byte;
    logic [SLOT_W-1:0]  slot_number;
    logic [INDEX_W-1:0] byte_index;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] read_byte;
    logic [LEN_W-1:0]  length_of_row;
    logic [SLOT_W-1:0] assigned_slot;
  } out_item_t;

  typedef struct packed {
    logic latch_item;
    logic do_insert;
    logic rd_check;
    logic rd_finish;
  } spr_cmd_t;

  typedef struct packed {
    logic item_is_read;
  } spr_stat_t;

endpackage

// ===== hdl/spr_ram.sv =====
// ----------------------------------------------------------------------------
// spr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module spr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/spr_ctrl.sv =====
// ----------------------------------------------------------------------------
// spr_ctrl
// Sequencer: accepts an item, steps inserts and reads through the datapath.
// ----------------------------------------------------------------------------
module spr_ctrl
  import spr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  spr_stat_t stat,
  output spr_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INSERT  = 3'd1;
  localparam logic [2:0] S_RD_SLOT = 3'd2;
  localparam logic [2:0] S_RD_PAGE = 3'd3;
  localparam logic [2:0] S_RD_DONE = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch_item = 1'b1;
          state_nxt      = S_RD_SLOT;
        end
      end
      S_RD_SLOT: begin
        // item latched last edge; decide path here
        state_nxt = stat.item_is_read ? S_RD_PAGE : S_INSERT;
        if (!stat.item_is_read) begin
          cmd.do_insert = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_RD_PAGE: begin
        cmd.rd_check = 1'b1;
        state_nxt    = S_RD_DONE;
      end
      S_RD_DONE: begin
        cmd.rd_finish = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_INSERT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== hdl/spr_datapath.sv =====
// ----------------------------------------------------------------------------
// spr_datapath
// Page pointers, slot directory and page memories, fit check and result
// register.
// ----------------------------------------------------------------------------
module spr_datapath
  import spr_pkg::*;
#(
  parameter int PAGE_BYTES   = 4096,
  parameter int HEADER_BYTES = 4,
  parameter int SLOT_BYTES   = 6,
  parameter int MAX_SLOTS    = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  spr_cmd_t  cmd,
  output spr_stat_t stat,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int PAGE_AW = $clog2(PAGE_BYTES);
  localparam int SLOT_AW = $clog2(MAX_SLOTS);
  localparam int FP_W    = $clog2(PAGE_BYTES + 1);
  localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
  localparam int CMP_W   =
    $clog2(HEADER_BYTES + (MAX_SLOTS + 1) * SLOT_BYTES + PAGE_BYTES + (1 << LEN_W) + 1);
  localparam int SN_W    = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
  localparam int AX_W    = ((PAGE_AW > LEN_W) ? PAGE_AW : LEN_W) + 1;
  localparam int SE_W    = PAGE_AW + LEN_W;

  in_item_t           req_r;
  logic [FP_W-1:0]    free_ptr_r,  free_ptr_nxt;
  logic [CNT_W-1:0]   row_count_r, row_count_nxt;
  logic [CMP_W-1:0]   dir_end_r,   dir_end_nxt;
  logic [LEN_W-1:0]   wpos_r,      wpos_nxt;
  logic               drop_r,      drop_nxt;
  logic [PAGE_AW-1:0] last_off_r,  last_off_nxt;
  logic [LEN_W-1:0]   last_len_r,  last_len_nxt;
  logic [STAT_W-1:0]  rd_status_r;
  logic [LEN_W-1:0]   rd_len_r;
  logic               out_valid_r;
  out_item_t          out_item_r,  out_item_nxt;

  logic               slot_we;
  logic [SLOT_AW-1:0] slot_waddr;
  logic [SE_W-1:0]    slot_wdata;
  logic [SLOT_AW-1:0] slot_raddr;
  logic [SE_W-1:0]    slot_rdata;
  logic               page_we;
  logic [PAGE_AW-1:0] page_waddr;
  logic [BYTE_W-1:0]  page_wdata;
  logic [PAGE_AW-1:0] page_raddr;
  logic [BYTE_W-1:0]  page_rdata;

  logic [SN_W-1:0]    sn_ext, cnt_ext, last_slot_ext;
  logic [CNT_W-1:0]   last_slot;
  logic [CMP_W-1:0]   need, fp_ext;
  logic               fits;
  logic [FP_W-1:0]    new_fp;
  logic [AX_W-1:0]    wr_addr_x, rd_addr_x;
  logic [PAGE_AW-1:0] rd_off;
  logic [LEN_W-1:0]   rd_len;
  logic [STAT_W-1:0]  rd_status;

  assign stat.item_is_read = (req_r.req_type == REQ_READ);

  // fit check and pointer arithmetic
  assign sn_ext        = SN_W'(req_r.slot_number);
  assign cnt_ext       = SN_W'(row_count_r);
  assign last_slot     = row_count_r - CNT_W'(1);
  assign last_slot_ext = SN_W'(last_slot);
  assign need          = dir_end_r + CMP_W'(req_r.row_length);
  assign fp_ext        = CMP_W'(free_ptr_r);
  assign fits          = (row_count_r < CNT_W'(MAX_SLOTS)) && (fp_ext >= need);
  assign new_fp        = free_ptr_r - FP_W'(req_r.row_length);
  assign wr_addr_x     = AX_W'(last_off_r) + AX_W'(wpos_r);

  always_comb begin
    free_ptr_nxt  = free_ptr_r;
    row_count_nxt = row_count_r;
    dir_end_nxt   = dir_end_r;
    wpos_nxt      = wpos_r;
    drop_nxt      = drop_r;
    last_off_nxt  = last_off_r;
    last_len_nxt  = last_len_r;
    slot_we       = 1'b0;
    slot_waddr    = row_count_r[SLOT_AW-1:0];
    slot_wdata    = {new_fp[PAGE_AW-1:0], req_r.row_length};
    page_we       = 1'b0;
    page_waddr    = wr_addr_x[PAGE_AW-1:0];
    page_wdata    = req_r.data_byte;
    out_item_nxt  = out_item_r;

    if (cmd.do_insert) begin
      out_item_nxt = '0;
      if (req_r.row_first) begin
        wpos_nxt = '0;
        if (fits) begin
          free_ptr_nxt  = new_fp;
          row_count_nxt = row_count_r + CNT_W'(1);
          dir_end_nxt   = dir_end_r + CMP_W'(SLOT_BYTES);
          drop_nxt      = 1'b0;
          last_off_nxt  = new_fp[PAGE_AW-1:0];
          last_len_nxt  = req_r.row_length;
          slot_we       = 1'b1;
          out_item_nxt.assigned_slot = cnt_ext[SLOT_W-1:0];
          if (req_r.row_length != '0) begin
            page_we    = 1'b1;
            page_waddr = new_fp[PAGE_AW-1:0];
            wpos_nxt   = LEN_W'(1);
          end
        end else begin
          drop_nxt            = 1'b1;
          out_item_nxt.status = ST_FULL;
        end
      end else if (drop_r) begin
        out_item_nxt.status = ST_FULL;
      end else if (row_count_r != '0) begin
        out_item_nxt.assigned_slot = last_slot_ext[SLOT_W-1:0];
        if (wpos_r < last_len_r) begin
          page_we  = 1'b1;
          wpos_nxt = wpos_r + LEN_W'(1);
        end
      end
    end

    if (cmd.rd_finish) begin
      out_item_nxt               = '0;
      out_item_nxt.status        = rd_status_r;
      out_item_nxt.length_of_row = rd_len_r;
      if (rd_status_r == ST_OK) begin
        out_item_nxt.read_byte = page_rdata;
      end
    end
  end

  // read path: slot entry is valid while rd_check is asserted
  assign slot_raddr = sn_ext[SLOT_AW-1:0];
  assign rd_off     = slot_rdata[SE_W-1:LEN_W];
  assign rd_len     = slot_rdata[LEN_W-1:0];
  assign rd_addr_x  = AX_W'(rd_off) + AX_W'(req_r.byte_index);
  assign page_raddr = rd_addr_x[PAGE_AW-1:0];

  always_comb begin
    if (sn_ext >= cnt_ext) begin
      rd_status = ST_NO_SLOT;
    end else if (LEN_W'(req_r.byte_index) >= rd_len) begin
      rd_status = ST_PAST_END;
    end else begin
      rd_status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      req_r <= in_item;
    end
    if (cmd.rd_check) begin
      rd_status_r <= rd_status;
      rd_len_r    <= (rd_status == ST_NO_SLOT) ? '0 : rd_len;
    end
    last_off_r <= last_off_nxt;
    last_len_r <= last_len_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_ptr_r  <= FP_W'(PAGE_BYTES);
      row_count_r <= '0;
      dir_end_r   <= CMP_W'(HEADER_BYTES + SLOT_BYTES);
      wpos_r      <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      free_ptr_r  <= free_ptr_nxt;
      row_count_r <= row_count_nxt;
      dir_end_r   <= dir_end_nxt;
      wpos_r      <= wpos_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= cmd.do_insert | cmd.rd_finish;
    end
  end

  spr_ram #(
    .WIDTH (SE_W),
    .DEPTH (MAX_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  spr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PAGE_BYTES)
  ) u_page_ram (
    .clk   (clk),
    .we    (page_we),
    .waddr (page_waddr),
    .wdata (page_wdata),
    .raddr (page_raddr),
    .rdata (page_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== hdl/slotted_page_row_store.sv =====
// ----------------------------------------------------------------------------
// slotted_page_row_store
// One database page of variable-length rows with a slot directory.
//
// Input: an item is taken at a rising edge with start high and busy low.
// An insert item carries one row byte; the first item of a row carries
// the row length and is checked against the room left between the slot
// directory and the free pointer. A read item names a slot and a byte.
// Output: out_valid is high for exactly one cycle with out_item; the
// receiver cannot stall, so every result is taken in that cycle.
// Timing: an insert item's result comes from the result register, and
// busy is low again in the cycle it appears, so a new item is taken only
// once the last one is through. A read passes through the slot directory
// RAM read, then the dependent page RAM read, then the result register.
// Reset (synchronous, rst_n low): empty page, free pointer at the page
// end, no row open. Directory and page RAMs are not cleared; the user must
// read an entry only once written; row bytes are not checked by the block.
// ----------------------------------------------------------------------------
module slotted_page_row_store
  import spr_pkg::*;
#(
  parameter int PAGE_BYTES   = 4096,
  parameter int HEADER_BYTES = 4,
  parameter int SLOT_BYTES   = 6,
  parameter int MAX_SLOTS    = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  spr_cmd_t  cmd;
  spr_stat_t stat;

  spr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  spr_datapath #(
    .PAGE_BYTES   (PAGE_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .SLOT_BYTES   (SLOT_BYTES),
    .MAX_SLOTS    (MAX_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
